// ----- rtl/core/gzhp_pkg.sv -----
// Shared types and constants for the gzip member header parser.
// No dependencies; every other file in rtl/core refers to this package.

package gzhp_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int HLEN_W   = 15;
   localparam int SKIP_W   = 16;
   localparam int FIDX_W   = 4;
   localparam int FLAGS_W  = 4;
   localparam int CNT_W    = 17;   // header byte count, holds any HEADER_LIMIT up to 65536

   // APB register map: one 32-bit register per word
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_GZIP_MODE = 1'b0;   // word index, paddr[2]

   // Header byte values
   localparam logic [BYTE_W-1:0] MAGIC_ID1   = 8'h1f;
   localparam logic [BYTE_W-1:0] MAGIC_ID2   = 8'h8b;
   localparam logic [BYTE_W-1:0] METHOD_CODE = 8'h08;

   // Positions within the 10-byte fixed part
   localparam logic [FIDX_W-1:0] FIX_ID1    = 4'd0;
   localparam logic [FIDX_W-1:0] FIX_ID2    = 4'd1;
   localparam logic [FIDX_W-1:0] FIX_METHOD = 4'd2;
   localparam logic [FIDX_W-1:0] FIX_FLAGS  = 4'd3;
   localparam logic [FIDX_W-1:0] FIX_LAST   = 4'd9;

   // option_flags bits (flag byte bits 1..4)
   localparam int OPT_PART    = 0;   // 0x02
   localparam int OPT_EXTRA   = 1;   // 0x04
   localparam int OPT_NAME    = 2;   // 0x08
   localparam int OPT_COMMENT = 3;   // 0x10

   localparam logic [SKIP_W-1:0] PART_LEN = 16'd2;

   typedef enum logic [3:0] {
      PH_FIXED      = 4'd0,
      PH_PART       = 4'd1,
      PH_XLEN_LO    = 4'd2,
      PH_XLEN_HI    = 4'd3,
      PH_EXTRA      = 4'd4,
      PH_NAME       = 4'd5,
      PH_COMMENT    = 4'd6,
      PH_PAYLOAD    = 4'd7,
      PH_ERR_MAGIC  = 4'd8,
      PH_ERR_METHOD = 4'd9,
      PH_ERR_TRUNC  = 4'd10,
      PH_ERR_LONG   = 4'd11
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HEADER      = 3'd0,
      ST_HEADER_DONE = 3'd1,
      ST_PAYLOAD     = 3'd2,
      ST_BAD_MAGIC   = 3'd3,
      ST_BAD_METHOD  = 3'd4,
      ST_TRUNCATED   = 3'd5,
      ST_TOO_LONG    = 3'd6
   } status_type;

   typedef struct packed {
      phase_type           phase;
      logic [FIDX_W-1:0]   fixed_index;
      logic [FLAGS_W-1:0]  option_flags;
      logic [SKIP_W-1:0]   skip_remaining;
      logic [BYTE_W-1:0]   extra_len_low;
   } parse_state_type;

   // First enabled optional part at or after 'from'; payload when none is left.
   function automatic phase_type enter_from(input phase_type from,
                                            input logic [FLAGS_W-1:0] flags);
      phase_type ph;
      if (from <= PH_PART && flags[OPT_PART]) begin
         ph = PH_PART;
      end else if (from <= PH_XLEN_LO && flags[OPT_EXTRA]) begin
         ph = PH_XLEN_LO;
      end else if (from <= PH_NAME && flags[OPT_NAME]) begin
         ph = PH_NAME;
      end else if (from <= PH_COMMENT && flags[OPT_COMMENT]) begin
         ph = PH_COMMENT;
      end else begin
         ph = PH_PAYLOAD;
      end
      return ph;
   endfunction

endpackage

// ----- rtl/core/gzhp_if.sv -----
// Valid/ready channel interfaces for the request (byte in) and response sides.
// Depends on gzhp_pkg for field widths.

interface gzhp_req_if;
   logic                        valid;
   logic                        ready;
   logic [gzhp_pkg::BYTE_W-1:0] in_byte;
   logic                        restart;
   logic                        end_of_input;

   modport source (output valid, in_byte, restart, end_of_input, input ready);
   modport sink   (input valid, in_byte, restart, end_of_input, output ready);
endinterface

interface gzhp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gzhp_pkg::BYTE_W-1:0]   out_byte;
   logic [gzhp_pkg::STATUS_W-1:0] status;
   logic [gzhp_pkg::HLEN_W-1:0]   header_length;
   logic                          out_last;

   modport source (output valid, out_byte, status, header_length, out_last, input ready);
   modport sink   (input valid, out_byte, status, header_length, out_last, output ready);
endinterface

// ----- rtl/core/gzip_header_parser.sv -----
// Top level of the gzip member header parser: channels, APB register, state.
// Depends on gzhp_pkg, gzhp_if.sv (gzhp_req_if, gzhp_rsp_if) and gzhp_parse.

// One byte goes in per request beat and exactly one response beat comes out
// for it, in order. The block sustains one byte per clock unless the response
// side stalls: a request is taken whenever the response register is empty or
// drained in the same cycle; the response follows in the next cycle. The whole
// per-byte header step (phase compare, skip counter decrement, header byte
// count and limit compare) sits between the parser state registers and the
// response register. In gzip mode (register 0 = 1, the reset value) the
// member header is checked and stripped: status 0 for header bytes, 1 on the
// byte that completes the header, 2 for payload, and 3..6 for bad magic, bad
// method, truncated and too long. Errors are sticky until a beat with restart
// set, which starts a new header at that byte in both modes. With register
// 0 = 0 every byte is payload and the parser state is frozen. Change gzip_mode
// only when no response is outstanding. HEADER_LIMIT bounds the header length.

module gzip_header_parser #(
   parameter int HEADER_LIMIT = 16384
) (
   input  logic                                clock,
   input  logic                                reset,

   gzhp_req_if.sink                            req_chan,
   gzhp_rsp_if.source                          rsp_chan,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gzhp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [gzhp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [gzhp_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   // configuration
   logic gzip_mode_ff;
   logic csr_write;

   // parser state
   gzhp_pkg::parse_state_type    state_ff, state_in;
   logic [gzhp_pkg::CNT_W-1:0]   count_ff, count_in;

   // response register
   logic                          rsp_valid_ff;
   logic [gzhp_pkg::BYTE_W-1:0]   rsp_byte_ff;
   logic [gzhp_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [gzhp_pkg::HLEN_W-1:0]   rsp_len_ff;
   logic                          rsp_last_ff;

   gzhp_pkg::status_type          step_status;
   logic [gzhp_pkg::HLEN_W-1:0]   step_len;
   logic                          req_ready;
   logic                          req_take;

   // ---------------------------------------------------------------- APB
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      prdata = '0;
      if (paddr[2] == gzhp_pkg::REG_GZIP_MODE) begin
         prdata[0] = gzip_mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gzip_mode_ff <= 1'b1;
      end else if (csr_write && paddr[2] == gzhp_pkg::REG_GZIP_MODE) begin
         gzip_mode_ff <= pwdata[0];
      end
   end

   // ---------------------------------------------------------- handshake
   // the response register frees itself in the same cycle it is drained
   assign req_ready      = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   // ------------------------------------------------------- header step
   gzhp_parse #(
      .HEADER_LIMIT (HEADER_LIMIT)
   ) u_parse (
      .gzip_mode     (gzip_mode_ff),
      .in_byte       (req_chan.in_byte),
      .restart       (req_chan.restart),
      .last          (req_chan.end_of_input),
      .cur_state     (state_ff),
      .cur_count     (count_ff),
      .next_state    (state_in),
      .next_count    (count_in),
      .status        (step_status),
      .header_length (step_len)
   );

   // parser state advances only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= gzhp_pkg::PH_FIXED;
         state_ff.fixed_index    <= '0;
         state_ff.option_flags   <= '0;
         state_ff.skip_remaining <= '0;
         state_ff.extra_len_low  <= '0;
         count_ff                <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------ response side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_byte_ff   <= req_chan.in_byte;
         rsp_status_ff <= step_status;
         rsp_len_ff    <= step_len;
         rsp_last_ff   <= req_chan.end_of_input;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_byte      = rsp_byte_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.header_length = rsp_len_ff;
   assign rsp_chan.out_last      = rsp_last_ff;

endmodule

// ----- rtl/core/gzhp_parse.sv -----
// Per-beat next-state and status logic of the gzip header parser.
// Purely combinational; depends on gzhp_pkg.

module gzhp_parse #(
   parameter int HEADER_LIMIT = 16384
) (
   input  logic                              gzip_mode,
   input  logic [gzhp_pkg::BYTE_W-1:0]       in_byte,
   input  logic                              restart,
   input  logic                              last,
   input  gzhp_pkg::parse_state_type         cur_state,
   input  logic [gzhp_pkg::CNT_W-1:0]        cur_count,
   output gzhp_pkg::parse_state_type         next_state,
   output logic [gzhp_pkg::CNT_W-1:0]        next_count,
   output gzhp_pkg::status_type              status,
   output logic [gzhp_pkg::HLEN_W-1:0]       header_length
);

   localparam logic [gzhp_pkg::CNT_W-1:0] LimitValue = gzhp_pkg::CNT_W'(HEADER_LIMIT);

   gzhp_pkg::parse_state_type st;
   logic [gzhp_pkg::CNT_W-1:0]  cnt;
   logic [gzhp_pkg::SKIP_W-1:0] skip_dec;
   logic                      err;

   always_comb begin
      // restart clears the parser before this byte is looked at
      if (restart) begin
         st.phase          = gzhp_pkg::PH_FIXED;
         st.fixed_index    = '0;
         st.option_flags   = '0;
         st.skip_remaining = '0;
         st.extra_len_low  = '0;
         cnt               = '0;
      end else begin
         st  = cur_state;
         cnt = cur_count;
      end

      next_state = st;
      next_count = cnt;
      err        = 1'b0;
      skip_dec   = st.skip_remaining - gzhp_pkg::SKIP_W'(1);
      status     = gzhp_pkg::ST_PAYLOAD;

      if (gzip_mode) begin
         case (st.phase)
            gzhp_pkg::PH_PAYLOAD: begin
               status = gzhp_pkg::ST_PAYLOAD;
            end
            gzhp_pkg::PH_ERR_MAGIC:  status = gzhp_pkg::ST_BAD_MAGIC;
            gzhp_pkg::PH_ERR_METHOD: status = gzhp_pkg::ST_BAD_METHOD;
            gzhp_pkg::PH_ERR_TRUNC:  status = gzhp_pkg::ST_TRUNCATED;
            gzhp_pkg::PH_ERR_LONG:   status = gzhp_pkg::ST_TOO_LONG;
            default: begin
               next_count = cnt + gzhp_pkg::CNT_W'(1);
               case (st.phase)
                  gzhp_pkg::PH_FIXED: begin
                     if ((st.fixed_index == gzhp_pkg::FIX_ID1 && in_byte != gzhp_pkg::MAGIC_ID1) ||
                         (st.fixed_index == gzhp_pkg::FIX_ID2 && in_byte != gzhp_pkg::MAGIC_ID2)) begin
                        next_state.phase = gzhp_pkg::PH_ERR_MAGIC;
                        err = 1'b1;
                     end else if (st.fixed_index == gzhp_pkg::FIX_METHOD &&
                                  in_byte != gzhp_pkg::METHOD_CODE) begin
                        next_state.phase = gzhp_pkg::PH_ERR_METHOD;
                        err = 1'b1;
                     end else begin
                        if (st.fixed_index == gzhp_pkg::FIX_FLAGS) begin
                           next_state.option_flags = in_byte[gzhp_pkg::FLAGS_W:1];
                        end
                        next_state.fixed_index = st.fixed_index + gzhp_pkg::FIDX_W'(1);
                        if (st.fixed_index >= gzhp_pkg::FIX_LAST) begin
                           next_state.phase = gzhp_pkg::enter_from(gzhp_pkg::PH_PART,
                                                                   st.option_flags);
                           if (next_state.phase == gzhp_pkg::PH_PART) begin
                              next_state.skip_remaining = gzhp_pkg::PART_LEN;
                           end
                        end
                     end
                  end
                  gzhp_pkg::PH_PART: begin
                     next_state.skip_remaining = skip_dec;
                     if (skip_dec == '0) begin
                        next_state.phase = gzhp_pkg::enter_from(gzhp_pkg::PH_XLEN_LO,
                                                                st.option_flags);
                     end
                  end
                  gzhp_pkg::PH_XLEN_LO: begin
                     next_state.extra_len_low = in_byte;
                     next_state.phase         = gzhp_pkg::PH_XLEN_HI;
                  end
                  gzhp_pkg::PH_XLEN_HI: begin
                     next_state.skip_remaining = {in_byte, st.extra_len_low};
                     if ({in_byte, st.extra_len_low} != '0) begin
                        next_state.phase = gzhp_pkg::PH_EXTRA;
                     end else begin
                        next_state.phase = gzhp_pkg::enter_from(gzhp_pkg::PH_NAME,
                                                                st.option_flags);
                     end
                  end
                  gzhp_pkg::PH_EXTRA: begin
                     next_state.skip_remaining = skip_dec;
                     if (skip_dec == '0) begin
                        next_state.phase = gzhp_pkg::enter_from(gzhp_pkg::PH_NAME,
                                                                st.option_flags);
                     end
                  end
                  gzhp_pkg::PH_NAME: begin
                     if (in_byte == '0) begin
                        next_state.phase = gzhp_pkg::enter_from(gzhp_pkg::PH_COMMENT,
                                                                st.option_flags);
                     end
                  end
                  default: begin   // comment string
                     if (in_byte == '0) begin
                        next_state.phase = gzhp_pkg::PH_PAYLOAD;
                     end
                  end
               endcase

               // error priority: bad byte, then too long, then truncated
               if (err) begin
                  if (next_state.phase == gzhp_pkg::PH_ERR_MAGIC) begin
                     status = gzhp_pkg::ST_BAD_MAGIC;
                  end else begin
                     status = gzhp_pkg::ST_BAD_METHOD;
                  end
               end else if (next_state.phase == gzhp_pkg::PH_PAYLOAD) begin
                  status = gzhp_pkg::ST_HEADER_DONE;
               end else if (next_count >= LimitValue) begin
                  next_state.phase = gzhp_pkg::PH_ERR_LONG;
                  status = gzhp_pkg::ST_TOO_LONG;
               end else if (last) begin
                  next_state.phase = gzhp_pkg::PH_ERR_TRUNC;
                  status = gzhp_pkg::ST_TRUNCATED;
               end else begin
                  status = gzhp_pkg::ST_HEADER;
               end
            end
         endcase
         header_length = next_count[gzhp_pkg::HLEN_W-1:0];
      end else begin
         // raw mode: parser state kept (apart from a restart), every byte payload
         header_length = '0;
      end
   end

endmodule

// ----- tb/gzip_header_parser_tb.sv -----
// Testbench for gzip_header_parser: byte stream in, one checked response beat per byte.
// Uses gzhp_pkg and the gzhp_req_if / gzhp_rsp_if channel interfaces from the RTL.

module gzip_header_parser_tb;
   import gzhp_pkg::*;

   localparam int HEADER_LIMIT = 16384;
   localparam int RANDOM_BEATS = 1790;
   // About 1.9k beats in all; even the longest sender gap plus the longest
   // receiver stall on every beat stays far below this.
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 25;
   localparam logic [CSR_ADDR_W-1:0] GZIP_MODE_ADDR = {REG_GZIP_MODE, 2'b00};

   // One response beat as the parser should produce it
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      status_type        status;
      logic [HLEN_W-1:0] header_length;
      logic              out_last;
   } parser_beat_t;

   // One request beat of a generated member
   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              restart;
      logic              last;
   } stream_byte_t;

   logic clock;
   logic reset;

   gzhp_req_if req_chan ();
   gzhp_rsp_if rsp_chan ();

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   gzip_header_parser #(
      .HEADER_LIMIT (HEADER_LIMIT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow of the parser: mode register plus header-walk state
   logic              track_gzip_mode;
   phase_type         track_phase;
   logic [FIDX_W-1:0] track_fixed_idx;
   logic [FLAGS_W-1:0] track_flags;
   logic [SKIP_W-1:0] track_skip;
   logic [BYTE_W-1:0] track_xlen_lo;
   int                track_count;

   parser_beat_t expected_beats[$];
   stream_byte_t member_bytes[$];

   int  mismatches    = 0;
   int  beats_sent    = 0;
   int  beats_checked = 0;
   int  members_sent  = 0;
   int  cycle_count   = 0;
   int  stall_left    = 0;
   bit  gaps_on       = 1'b1;
   bit  stalls_on     = 1'b1;

   //------------------------------------------------------------------
   // Clock, timeout
   //------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still expected",
                  cycle_count, expected_beats.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   //------------------------------------------------------------------
   // Header-walk predictor
   //------------------------------------------------------------------
   function automatic void clear_tracker();
      track_phase     = PH_FIXED;
      track_fixed_idx = '0;
      track_flags     = '0;
      track_skip      = '0;
      track_xlen_lo   = '0;
      track_count     = 0;
   endfunction

   // First optional section enabled at or past 'from'; payload when none left
   function automatic phase_type next_section(phase_type from);
      if (from <= PH_PART && track_flags[OPT_PART]) return PH_PART;
      if (from <= PH_XLEN_LO && track_flags[OPT_EXTRA]) return PH_XLEN_LO;
      if (from <= PH_NAME && track_flags[OPT_NAME]) return PH_NAME;
      if (from <= PH_COMMENT && track_flags[OPT_COMMENT]) return PH_COMMENT;
      return PH_PAYLOAD;
   endfunction

   function automatic status_type sticky_status(phase_type ph);
      case (ph)
         PH_ERR_MAGIC:  return ST_BAD_MAGIC;
         PH_ERR_METHOD: return ST_BAD_METHOD;
         PH_ERR_TRUNC:  return ST_TRUNCATED;
         default:       return ST_TOO_LONG;
      endcase
   endfunction

   // Advances the shadow state by one accepted byte, returns the expected beat
   function automatic parser_beat_t parse_header_byte(logic [BYTE_W-1:0] data,
                                                      logic rst, logic last);
      parser_beat_t beat;
      logic         bad;
      beat.out_byte      = data;
      beat.out_last      = last;
      beat.status        = ST_PAYLOAD;
      beat.header_length = '0;
      bad = 1'b0;
      if (rst) clear_tracker();
      // raw mode: payload, length 0, header state frozen
      if (track_gzip_mode == 1'b0) return beat;

      if (track_phase >= PH_ERR_MAGIC) begin
         beat.status = sticky_status(track_phase);
      end else if (track_phase == PH_PAYLOAD) begin
         beat.status = ST_PAYLOAD;
      end else begin
         track_count++;
         case (track_phase)
            PH_FIXED: begin
               if ((track_fixed_idx == FIX_ID1 && data != MAGIC_ID1) ||
                   (track_fixed_idx == FIX_ID2 && data != MAGIC_ID2)) begin
                  track_phase = PH_ERR_MAGIC;
                  bad = 1'b1;
               end else if (track_fixed_idx == FIX_METHOD && data != METHOD_CODE) begin
                  track_phase = PH_ERR_METHOD;
                  bad = 1'b1;
               end else begin
                  if (track_fixed_idx == FIX_FLAGS) track_flags = data[4:1];
                  if (track_fixed_idx >= FIX_LAST) begin
                     track_phase = next_section(PH_PART);
                     if (track_phase == PH_PART) track_skip = PART_LEN;
                  end
                  track_fixed_idx = track_fixed_idx + 1'b1;
               end
            end
            PH_PART: begin
               track_skip = track_skip - 1'b1;
               if (track_skip == 0) track_phase = next_section(PH_XLEN_LO);
            end
            PH_XLEN_LO: begin
               track_xlen_lo = data;
               track_phase   = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
               track_skip  = {data, track_xlen_lo};
               track_phase = (track_skip != 0) ? PH_EXTRA : next_section(PH_NAME);
            end
            PH_EXTRA: begin
               track_skip = track_skip - 1'b1;
               if (track_skip == 0) track_phase = next_section(PH_NAME);
            end
            PH_NAME: begin
               if (data == 0) track_phase = next_section(PH_COMMENT);
            end
            default: begin
               if (data == 0) track_phase = PH_PAYLOAD;
            end
         endcase
         // priority: magic/method, header done, too long, truncated
         if (bad) begin
            beat.status = sticky_status(track_phase);
         end else if (track_phase == PH_PAYLOAD) begin
            beat.status = ST_HEADER_DONE;
         end else if (track_count >= HEADER_LIMIT) begin
            track_phase = PH_ERR_LONG;
            beat.status = ST_TOO_LONG;
         end else if (last) begin
            track_phase = PH_ERR_TRUNC;
            beat.status = ST_TRUNCATED;
         end else begin
            beat.status = ST_HEADER;
         end
      end
      beat.header_length = track_count[HLEN_W-1:0];
      return beat;
   endfunction

   //------------------------------------------------------------------
   // Mismatch reporting and response checking
   //------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, what);
   endtask

   task automatic check_beat();
      parser_beat_t exp;
      if (expected_beats.size() == 0) begin
         report_mismatch($sformatf("response beat with nothing expected, out_byte %02h",
                                   rsp_chan.out_byte));
         return;
      end
      exp = expected_beats.pop_front();
      if (rsp_chan.out_byte !== exp.out_byte)
         report_mismatch($sformatf("beat %0d out_byte %02h, expected %02h",
                                   beats_checked, rsp_chan.out_byte, exp.out_byte));
      if (rsp_chan.status !== exp.status)
         report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                   beats_checked, rsp_chan.status, exp.status));
      if (rsp_chan.header_length !== exp.header_length)
         report_mismatch($sformatf("beat %0d header_length %0d, expected %0d",
                                   beats_checked, rsp_chan.header_length, exp.header_length));
      if (rsp_chan.out_last !== exp.out_last)
         report_mismatch($sformatf("beat %0d out_last %0b, expected %0b",
                                   beats_checked, rsp_chan.out_last, exp.out_last));
      beats_checked++;
   endtask

   // Checks each response beat and drives ready with random stalls,
   // mostly short, now and then long.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) check_beat();
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (stalls_on && $urandom_range(0, 99) < 15) begin
         rsp_chan.ready <= 1'b0;
         stall_left = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(5, 30);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   //------------------------------------------------------------------
   // Request side
   //------------------------------------------------------------------
   // Holds one beat until accepted; then optionally drops valid for a gap.
   task automatic send_beat(input logic [BYTE_W-1:0] data, input logic rst,
                            input logic last);
      int gap;
      int roll;
      gap = 0;
      req_chan.valid        <= 1'b1;
      req_chan.in_byte      <= data;
      req_chan.restart      <= rst;
      req_chan.end_of_input <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      expected_beats.push_back(parse_header_byte(data, rst, last));
      beats_sent++;
      if (gaps_on) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) gap = $urandom_range(1, 3);
         else if (roll < 24) gap = $urandom_range(6, 30);
      end
      if (gap != 0) begin
         req_chan.valid   <= 1'b0;
         req_chan.in_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender holds off until every response is back (block fully drained).
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // APB write of gzip_mode, then a read back of the same register
   task automatic write_gzip_mode(input logic mode);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= GZIP_MODE_ADDR;
      pwdata  <= {31'($urandom), mode};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      track_gzip_mode = mode;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[0] !== mode)
         report_mismatch($sformatf("gzip_mode read back %0b, expected %0b", prdata[0], mode));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Magic, method, flag byte, then six bytes alternating 00 / ff
   task automatic send_fixed_part(input logic [BYTE_W-1:0] flags, input logic rst);
      send_beat(MAGIC_ID1, rst, 1'b0);
      send_beat(MAGIC_ID2, 1'b0, 1'b0);
      send_beat(METHOD_CODE, 1'b0, 1'b0);
      send_beat(flags, 1'b0, 1'b0);
      for (int i = 0; i < 6; i++) send_beat(i[0] ? 8'hff : 8'h00, 1'b0, 1'b0);
   endtask

   //------------------------------------------------------------------
   // Tests
   //------------------------------------------------------------------
   // Every flag set (unused bits too), every optional section present
   task automatic test_full_header();
      send_fixed_part(8'hff, 1'b1);
      send_beat(8'ha5, 1'b0, 1'b0);            // part number
      send_beat(8'h5a, 1'b0, 1'b0);
      send_beat(8'h02, 1'b0, 1'b0);            // extra length 2
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hff, 1'b0, 1'b0);            // extra bytes
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h41, 1'b0, 1'b0);            // name "A"
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0);            // empty comment ends header
      send_beat(8'hff, 1'b0, 1'b0);            // payload
      send_beat(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_header_errors();
      // bad first magic byte on the last input byte: magic wins over truncated
      send_beat(8'h1e, 1'b1, 1'b1);
      send_beat(MAGIC_ID1, 1'b0, 1'b0);        // sticky
      // bad second magic byte
      send_beat(MAGIC_ID1, 1'b1, 1'b0);
      send_beat(8'h8a, 1'b0, 1'b0);
      // bad method
      send_beat(MAGIC_ID1, 1'b1, 1'b0);
      send_beat(MAGIC_ID2, 1'b0, 1'b0);
      send_beat(8'h09, 1'b0, 1'b0);
      // input ends on the flag byte, then sticky truncated
      send_beat(MAGIC_ID1, 1'b1, 1'b0);
      send_beat(MAGIC_ID2, 1'b0, 1'b0);
      send_beat(METHOD_CODE, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'h00, 1'b0, 1'b0);
      // zero extra length: header ends on the length high byte
      send_fixed_part(8'h04, 1'b1);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h7e, 1'b0, 1'b1);
   endtask

   // Raw mode freezes the walk; restart in raw mode still clears it
   task automatic test_raw_mode();
      send_beat(MAGIC_ID1, 1'b1, 1'b0);
      send_beat(MAGIC_ID2, 1'b0, 1'b0);
      wait_idle();
      write_gzip_mode(1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hff, 1'b0, 1'b1);
      wait_idle();
      write_gzip_mode(1'b1);
      send_beat(METHOD_CODE, 1'b0, 1'b0);      // resumes at the method byte
      send_beat(8'h00, 1'b0, 1'b0);
      for (int i = 0; i < 6; i++) send_beat(8'h3c, 1'b0, 1'b0);
      send_beat(8'h99, 1'b0, 1'b0);
      wait_idle();
      write_gzip_mode(1'b0);
      send_beat(8'h55, 1'b1, 1'b0);
      wait_idle();
      write_gzip_mode(1'b1);
      send_beat(MAGIC_ID1, 1'b0, 1'b0);        // counts as header byte 1 again
      send_beat(MAGIC_ID2, 1'b0, 1'b1);
   endtask

   // Builds one member (mostly well formed, random content), optionally
   // damaged or cut short inside the header, and streams it.
   task automatic send_member(input bit cut);
      logic [BYTE_W-1:0] flags;
      int xlen;
      int hdr_end;
      int roll;
      int pos;
      member_bytes.delete();
      if ($urandom_range(0, 19) == 0) begin
         // pure noise
         repeat ($urandom_range(3, 15))
            member_bytes.push_back('{8'($urandom), $urandom_range(0, 9) == 0,
                                     $urandom_range(0, 9) == 0});
      end else begin
         flags = 8'($urandom);
         member_bytes.push_back('{MAGIC_ID1, 1'b0, 1'b0});
         member_bytes.push_back('{MAGIC_ID2, 1'b0, 1'b0});
         member_bytes.push_back('{METHOD_CODE, 1'b0, 1'b0});
         member_bytes.push_back('{flags, 1'b0, 1'b0});
         repeat (6) member_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
         if (flags[1]) repeat (2) member_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
         if (flags[2]) begin
            xlen = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 60);
            member_bytes.push_back('{8'(xlen), 1'b0, 1'b0});
            member_bytes.push_back('{8'(xlen >> 8), 1'b0, 1'b0});
            repeat (xlen) member_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
         end
         if (flags[3]) begin
            repeat ($urandom_range(0, 6))
               member_bytes.push_back('{8'($urandom_range(1, 255)), 1'b0, 1'b0});
            member_bytes.push_back('{8'h00, 1'b0, 1'b0});
         end
         if (flags[4]) begin
            repeat ($urandom_range(0, 6))
               member_bytes.push_back('{8'($urandom_range(1, 255)), 1'b0, 1'b0});
            member_bytes.push_back('{8'h00, 1'b0, 1'b0});
         end
         hdr_end = member_bytes.size();
         repeat ($urandom_range(0, 10)) member_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
         for (int i = hdr_end; i < member_bytes.size(); i++)
            member_bytes[i].last = ($urandom_range(0, 99) < 8) ||
                                   (i == member_bytes.size() - 1 && $urandom_range(0, 2) == 0);
         member_bytes[0].restart = ($urandom_range(0, 9) != 0);
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            member_bytes[0].data = MAGIC_ID1 ^ 8'($urandom_range(1, 255));
         end else if (roll < 10) begin
            member_bytes[1].data = MAGIC_ID2 ^ 8'($urandom_range(1, 255));
         end else if (roll < 14) begin
            member_bytes[2].data = METHOD_CODE ^ 8'($urandom_range(1, 255));
         end else if (roll < 24) begin
            member_bytes[$urandom_range(0, hdr_end - 1)].last = 1'b1;
         end else if (roll < 27) begin
            // a stray restart somewhere inside the member
            pos = $urandom_range(1, member_bytes.size() - 1);
            member_bytes[pos].restart = 1'b1;
         end
         if (cut) member_bytes = member_bytes[0:$urandom_range(0, hdr_end - 2)];
      end
      foreach (member_bytes[i])
         send_beat(member_bytes[i].data, member_bytes[i].restart, member_bytes[i].last);
      members_sent++;
   endtask

   // Phases of several members each; mode, idling and drain points vary per phase.
   task automatic test_random_streams();
      int  start_beats;
      int  members;
      logic want_mode;
      start_beats = beats_sent;
      while (beats_sent - start_beats < RANDOM_BEATS) begin
         want_mode = ($urandom_range(0, 3) != 0);
         gaps_on   = ($urandom_range(0, 4) != 0);
         stalls_on = ($urandom_range(0, 4) != 0);
         if (want_mode != track_gzip_mode) begin
            wait_idle();
            write_gzip_mode(want_mode);
         end else if ($urandom_range(0, 3) == 0) begin
            wait_idle();
         end
         members = $urandom_range(2, 8);
         for (int m = 0; m < members; m++)
            send_member(m == members - 1 && $urandom_range(0, 6) == 0);
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   //------------------------------------------------------------------
   // Main sequence
   //------------------------------------------------------------------
   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.in_byte      <= '0;
      req_chan.restart      <= 1'b0;
      req_chan.end_of_input <= 1'b0;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      track_gzip_mode = 1'b1;
      clear_tracker();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_full_header();
      test_header_errors();
      test_raw_mode();
      test_random_streams();
      wait_idle();
      // leave the mode register at its reset value as the last setting
      write_gzip_mode(1'b1);
      repeat (3) @(posedge clock);

      $display("Run covered %0d beats in %0d random members plus directed headers,",
               beats_checked, members_sent);
      $display("both modes, restarts and the magic, method and truncation errors; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- gzip_header_parser.f -----
rtl/core/gzhp_pkg.sv
rtl/core/gzhp_if.sv
rtl/core/gzhp_parse.sv
rtl/core/gzip_header_parser.sv
tb/gzip_header_parser_tb.sv
